@@ hdl/sfrc_pkg.sv @@
// Shared constants, types and helper functions of the serial frame resync and CRC checker.
`timescale 1ns / 1ps

package sfrc_pkg;

    // Frame buffer geometry.
    localparam int BUF_DEPTH = 64;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // Largest frame a single item may produce, bounded by the buffer as well.
    localparam int LEN_CAP   = (BUF_DEPTH < 64) ? BUF_DEPTH : 64;

    localparam int MIN_TOTAL   = 4;
    localparam int HEADER_HELD = 3;
    localparam int LEN_EXTRA   = 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CRC_POLY  = 2'd0;
    localparam logic [1:0] CFG_SYNC_BYTE = 2'd1;
    localparam logic [1:0] CFG_ALT_START = 2'd2;
    localparam logic [1:0] CFG_MAX_LEN   = 2'd3;

    // Register reset values.
    localparam logic [7:0] RST_CRC_POLY  = 8'hD5;
    localparam logic [7:0] RST_SYNC_BYTE = 8'hC8;
    localparam logic [7:0] RST_ALT_START = 8'hEE;
    localparam logic [6:0] RST_MAX_LEN   = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_LEN,
        S_CRC,
        S_CHK,
        S_EMIT,
        S_ERR
    } t_state;

    // Circular buffer pointer plus an offset of at most one buffer length.
    function automatic logic [BUF_AW-1:0] ptr_add(input logic [BUF_AW-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
        logic [BUF_AW:0] sum;
        sum = {1'b0, base} + (BUF_AW + 1)'(off);
        if (sum >= (BUF_AW + 1)'(BUF_DEPTH)) begin
            sum = sum - (BUF_AW + 1)'(BUF_DEPTH);
        end
        return sum[BUF_AW-1:0];
    endfunction

    // Eight MSB-first shift steps of the CRC-8 register after the data byte is folded in.
    function automatic logic [7:0] crc8_shift(input logic [7:0] crc_in,
                                              input logic [7:0] poly);
        logic [7:0] crc;
        crc = crc_in;
        for (int b = 0; b < 8; b++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ poly;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

@@ hdl/sfrc_ram.sv @@
// Simple dual-port RAM with a registered read port, used as the frame buffer.
`timescale 1ns / 1ps

module sfrc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/serial_frame_resync_crc_check.sv @@
// Top level of the serial frame resync and CRC checker.
`timescale 1ns / 1ps

// Usage
// The receive channel (i_rx_valid, o_rx_stall, i_rx_byte) takes one serial byte per item.
// The block stalls the receive channel from the cycle after an item is accepted until all
// of its work is done; it then accepts the next item even if a result is still waiting.
// The result channel (o_res_valid, i_res_stall) delivers either the bytes of a good frame,
// one per item with o_last on the final byte, or a single error item with o_status set.
// Every result carries the good and bad frame counts, which saturate at 65535.
// Work per received byte: the byte is written and read back, then one buffer read per cycle
// while the buffer is searched for a start byte (up to the fill level, at most 64), a read
// of the length byte, one read per CRC byte (frame length minus three) and the check, then
// the emitted bytes one by one, or a single error item. The single read port of the
// frame buffer sets this pace. A byte that completes no frame needs no CRC pass and no
// emission; a bad length adds a new search.
// When the receiver stalls, emission waits with the pending byte held in the output
// register. Synchronous reset empties the buffer, clears both counters and restores
// the register defaults; the buffer contents themselves are not cleared.
// Configuration writes are always ready and should only be made while the block is idle.

module serial_frame_resync_crc_check
    import sfrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,

    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_last,
    output logic        o_status,
    output logic [15:0] o_good_frames,
    output logic [15:0] o_bad_frames,

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // Configuration registers.
    logic [7:0] r_crc_poly;
    logic [7:0] r_sync_byte;
    logic [7:0] r_alt_start;
    logic [6:0] r_max_len;

    // Sequencer state.
    t_state            r_state, n_state;
    logic [BUF_AW-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_off, n_off;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [7:0]        r_crc, n_crc;
    logic              r_realign1, n_realign1;
    logic [15:0]       r_good_cnt, n_good_cnt;
    logic [15:0]       r_bad_cnt, n_bad_cnt;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;
    logic        r_out_status, n_out_status;
    logic [15:0] r_out_good, n_out_good;
    logic [15:0] r_out_bad, n_out_bad;

    // Buffer port signals.
    logic              wr_en;
    logic [BUF_AW-1:0] wr_addr;
    logic [BUF_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    logic       rx_accept;
    logic       out_free;
    logic       is_start;
    logic [8:0] total_w;
    logic [6:0] limit;

    assign o_rx_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign rx_accept   = i_rx_valid && !o_rx_stall;
    assign out_free    = !r_out_valid || !i_res_stall;

    assign wr_en   = rx_accept;
    assign wr_addr = ptr_add(r_head, r_fill);
    assign rd_addr = ptr_add(n_head, n_off);

    assign is_start = (rd_data == r_sync_byte) || (rd_data == r_alt_start);
    assign total_w  = {1'b0, rd_data} + 9'(LEN_EXTRA);
    assign limit    = (r_max_len > 7'(LEN_CAP)) ? 7'(LEN_CAP) : r_max_len;

    sfrc_ram #(
        .DEPTH (BUF_DEPTH),
        .WIDTH (8)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_poly  <= RST_CRC_POLY;
            r_sync_byte <= RST_SYNC_BYTE;
            r_alt_start <= RST_ALT_START;
            r_max_len   <= RST_MAX_LEN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CRC_POLY:  r_crc_poly  <= i_cfg_data;
                CFG_SYNC_BYTE: r_sync_byte <= i_cfg_data;
                CFG_ALT_START: r_alt_start <= i_cfg_data;
                CFG_MAX_LEN:   r_max_len   <= i_cfg_data[6:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_off       <= '0;
            r_realign1  <= 1'b0;
            r_good_cnt  <= '0;
            r_bad_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_off       <= n_off;
            r_realign1  <= n_realign1;
            r_good_cnt  <= n_good_cnt;
            r_bad_cnt   <= n_bad_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total      <= n_total;
        r_crc        <= n_crc;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_out_good   <= n_out_good;
        r_out_bad    <= n_out_bad;
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_fill       = r_fill;
        n_off        = r_off;
        n_total      = r_total;
        n_crc        = r_crc;
        n_realign1   = r_realign1;
        n_good_cnt   = r_good_cnt;
        n_bad_cnt    = r_bad_cnt;
        n_out_valid  = r_out_valid && i_res_stall;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        n_out_good   = r_out_good;
        n_out_bad    = r_out_bad;

        unique case (r_state)
            S_IDLE: begin
                n_off      = '0;
                n_realign1 = 1'b0;
                if (rx_accept) begin
                    n_fill  = r_fill + CNT_W'(1);
                    n_state = S_START;
                end
            end

            // From here on the buffer is read from its head, including the byte written on acceptance.
            S_START: begin
                n_state = S_SCAN;
            end

            S_SCAN: begin
                if (is_start) begin
                    n_head = ptr_add(r_head, r_off);
                    n_fill = r_fill - r_off;
                    if (r_realign1 || n_fill < CNT_W'(HEADER_HELD)) begin
                        n_off   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_off   = CNT_W'(1);
                        n_state = S_LEN;
                    end
                end else if ((r_off + CNT_W'(1)) >= r_fill) begin
                    n_fill  = '0;
                    n_off   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_off = r_off + CNT_W'(1);
                end
            end

            S_LEN: begin
                if (total_w < 9'(MIN_TOTAL) || total_w > {2'b00, limit}) begin
                    // Bad length: drop the leading byte and search again from byte one.
                    n_off      = CNT_W'(1);
                    n_realign1 = 1'b1;
                    n_state    = S_SCAN;
                end else if (9'(r_fill) < total_w) begin
                    n_off   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_total = total_w[CNT_W-1:0];
                    n_crc   = '0;
                    n_off   = CNT_W'(2);
                    n_state = S_CRC;
                end
            end

            S_CRC: begin
                n_crc = crc8_shift(r_crc ^ rd_data, r_crc_poly);
                if (r_off == r_total - CNT_W'(2)) begin
                    n_off   = r_total - CNT_W'(1);
                    n_state = S_CHK;
                end else begin
                    n_off = r_off + CNT_W'(1);
                end
            end

            S_CHK: begin
                if (rd_data == r_crc) begin
                    if (r_good_cnt != 16'hFFFF) begin
                        n_good_cnt = r_good_cnt + 16'd1;
                    end
                    n_off   = '0;
                    n_state = S_EMIT;
                end else begin
                    if (r_bad_cnt != 16'hFFFF) begin
                        n_bad_cnt = r_bad_cnt + 16'd1;
                    end
                    n_state = S_ERR;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = rd_data;
                    n_out_status = 1'b0;
                    n_out_good   = r_good_cnt;
                    n_out_bad    = r_bad_cnt;
                    if (r_off == r_total - CNT_W'(1)) begin
                        n_out_last = 1'b1;
                        n_head     = ptr_add(r_head, r_total);
                        n_fill     = r_fill - r_total;
                        n_off      = '0;
                        n_state    = S_IDLE;
                    end else begin
                        n_out_last = 1'b0;
                        n_off      = r_off + CNT_W'(1);
                    end
                end
            end

            S_ERR: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = 8'h00;
                    n_out_last   = 1'b1;
                    n_out_status = 1'b1;
                    n_out_good   = r_good_cnt;
                    n_out_bad    = r_bad_cnt;
                    n_head       = ptr_add(r_head, r_total);
                    n_fill       = r_fill - r_total;
                    n_off        = '0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_valid   = r_out_valid;
    assign o_frame_byte  = r_out_byte;
    assign o_last        = r_out_last;
    assign o_status      = r_out_status;
    assign o_good_frames = r_out_good;
    assign o_bad_frames  = r_out_bad;

    // The buffer never overflows, so an accepted byte always finds room.
    a_room_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_accept |-> (r_fill < CNT_W'(BUF_DEPTH)))
        else $error("byte accepted into a full frame buffer");

    // An error item always closes with a zero byte.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status) |-> (o_last && o_frame_byte == 8'h00))
        else $error("malformed error item");

    // The good count only moves when a frame check has just passed.
    a_good_cnt_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_good_cnt != $past(r_good_cnt)) |-> ($past(r_state) == S_CHK))
        else $error("good count changed outside the frame check");

    // A frame under check is never longer than the bytes held.
    a_frame_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRC || r_state == S_CHK || r_state == S_EMIT) |-> (r_total <= r_fill))
        else $error("frame longer than the buffer contents");

endmodule

@@ dv/serial_frame_resync_crc_check_test.sv @@
// Self-checking testbench for the serial frame resync and CRC checker.
`timescale 1ns / 1ps

module serial_frame_resync_crc_check_test
    import sfrc_pkg::*;
();

    localparam int MAX_BURST    = 64;
    localparam int DRAIN_CYCLES = 300;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int SQUEEZE_AT   = 60;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        last;
        logic        status;
        logic [15:0] good;
        logic [15:0] bad;
    } t_frame_result;

    // Mirrors the frame buffer and counters and queues the results each byte should produce.
    class frame_scoreboard;
        logic [7:0]    poly;
        logic [7:0]    sync_b;
        logic [7:0]    alt_b;
        logic [6:0]    max_len;
        logic [7:0]    held[$];
        logic [15:0]   good_cnt;
        logic [15:0]   bad_cnt;
        t_frame_result pending[$];
        int unsigned   failures;

        function new();
            poly     = RST_CRC_POLY;
            sync_b   = RST_SYNC_BYTE;
            alt_b    = RST_ALT_START;
            max_len  = RST_MAX_LEN;
            good_cnt = '0;
            bad_cnt  = '0;
            failures = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                CFG_CRC_POLY:  poly    = data;
                CFG_SYNC_BYTE: sync_b  = data;
                CFG_ALT_START: alt_b   = data;
                CFG_MAX_LEN:   max_len = data[6:0];
                default: ;
            endcase
        endfunction

        function int frame_limit();
            int lim;
            lim = int'(max_len);
            if (lim > BUF_DEPTH) lim = BUF_DEPTH;
            if (lim > MAX_BURST) lim = MAX_BURST;
            return lim;
        endfunction

        function logic [7:0] crc8_over(logic [7:0] data[$], int first, int count);
            logic [7:0] crc;
            crc = '0;
            for (int k = 0; k < count; k++) begin
                crc ^= data[first + k];
                for (int b = 0; b < 8; b++) begin
                    if (crc[7]) begin
                        crc = {crc[6:0], 1'b0} ^ poly;
                    end else begin
                        crc = {crc[6:0], 1'b0};
                    end
                end
            end
            return crc;
        endfunction

        // Keeps the buffer from the first start byte at or after 'from', or empties it.
        function void drop_to_start(int from);
            for (int i = from; i < held.size(); i++) begin
                if (held[i] == sync_b || held[i] == alt_b) begin
                    for (int j = 0; j < i; j++) void'(held.pop_front());
                    return;
                end
            end
            held.delete();
        endfunction

        function void note_rx_byte(logic [7:0] b);
            int total;
            int lim;
            t_frame_result r;
            lim = frame_limit();
            if (held.size() < BUF_DEPTH) held.push_back(b);
            drop_to_start(0);
            if (held.size() < HEADER_HELD) return;
            total = int'(held[1]) + LEN_EXTRA;
            if (total < MIN_TOTAL || total > lim) begin
                drop_to_start(1);
                return;
            end
            if (held.size() < total) return;
            if (crc8_over(held, 2, total - HEADER_HELD) == held[total - 1]) begin
                if (good_cnt != 16'hFFFF) good_cnt++;
                for (int i = 0; i < total; i++) begin
                    r.frame_byte = held[i];
                    r.last       = (i == total - 1);
                    r.status     = 1'b0;
                    r.good       = good_cnt;
                    r.bad        = bad_cnt;
                    pending.push_back(r);
                end
            end else begin
                if (bad_cnt != 16'hFFFF) bad_cnt++;
                r.frame_byte = '0;
                r.last       = 1'b1;
                r.status     = 1'b1;
                r.good       = good_cnt;
                r.bad        = bad_cnt;
                pending.push_back(r);
            end
            for (int i = 0; i < total; i++) void'(held.pop_front());
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, got byte %0h last %0b status %0b",
                         $time, got.frame_byte, got.last, got.status);
                failures++;
                return;
            end
            want = pending.pop_front();
            compare_field("frame_byte", 16'(want.frame_byte), 16'(got.frame_byte));
            compare_field("last", 16'(want.last), 16'(got.last));
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("good_frames", want.good, got.good);
            compare_field("bad_frames", want.bad, got.bad);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte;
    logic        o_res_valid;
    logic        i_res_stall;
    logic [7:0]  o_frame_byte;
    logic        o_last;
    logic        o_status;
    logic [15:0] o_good_frames;
    logic [15:0] o_bad_frames;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    frame_scoreboard sb;
    bit              calm;
    int              bytes_sent;
    int              results_seen;

    serial_frame_resync_crc_check dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_stall    (o_rx_stall),
        .i_rx_byte     (i_rx_byte),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_frame_byte  (o_frame_byte),
        .o_last        (o_last),
        .o_status      (o_status),
        .o_good_frames (o_good_frames),
        .o_bad_frames  (o_bad_frames),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function logic [7:0] pick_start();
        return $urandom_range(0, 1) ? sb.sync_b : sb.alt_b;
    endfunction

    function int pick_total();
        int lim;
        lim = sb.frame_limit();
        if (lim < MIN_TOTAL) lim = 8;
        if ($urandom_range(0, 11) == 0) return $urandom_range(MIN_TOTAL, lim);
        return $urandom_range(MIN_TOTAL, (lim < 12) ? lim : 12);
    endfunction

    // A length byte that gives a total under the minimum or over the limit.
    function logic [7:0] bad_len(int lim);
        if ($urandom_range(0, 1)) return 8'($urandom_range(0, 1));
        return 8'($urandom_range(lim - 1, 255));
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_rx_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        sb.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(logic [7:0] start, int total, bit corrupt);
        logic [7:0] bytes[$];
        logic [7:0] crc;
        bytes.push_back(start);
        bytes.push_back(8'(total - LEN_EXTRA));
        for (int i = 2; i < total - 1; i++) bytes.push_back(8'($urandom_range(0, 255)));
        crc = sb.crc8_over(bytes, 2, total - HEADER_HELD);
        if (corrupt) crc ^= 8'($urandom_range(1, 255));
        bytes.push_back(crc);
        foreach (bytes[i]) send_byte(bytes[i]);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits for every expected result, then lets the block finish any silent work.
    task automatic drain();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && sb.pending.size() != 0; n++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [7:0] poly, logic [7:0] sync_v, logic [7:0] alt_v,
                             logic [7:0] max_v, bit quiet, int budget);
        int stop;
        int lim;
        int kind;
        int total;
        drain();
        write_reg(CFG_CRC_POLY, poly);
        write_reg(CFG_SYNC_BYTE, sync_v);
        write_reg(CFG_ALT_START, alt_v);
        write_reg(CFG_MAX_LEN, max_v);
        calm = quiet;
        stop = bytes_sent + budget;
        lim  = sb.frame_limit();
        if (lim >= MIN_TOTAL) send_frame(pick_start(), lim, 1'b0);
        while (bytes_sent < stop) begin
            kind = $urandom_range(0, 99);
            if (kind < 68) begin
                send_frame(pick_start(), pick_total(), 1'b0);
            end else if (kind < 80) begin
                send_frame(pick_start(), pick_total(), 1'b1);
            end else if (kind < 88) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end else if (kind < 95) begin
                send_byte(pick_start());
                send_byte(bad_len(lim));
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                // A header whose frame is cut short, so the following bytes become its body.
                total = pick_total();
                send_byte(pick_start());
                send_byte(8'(total - LEN_EXTRA));
                repeat ($urandom_range(0, total - 4)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            sb.check_result({o_frame_byte, o_last, o_status, o_good_frames, o_bad_frames});
            results_seen++;
        end
    end

    // Result side: random stalls, plus one long hold-off so the block backs up.
    initial begin
        int  stall_left;
        bit  squeezed;
        stall_left = 0;
        squeezed   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!squeezed && results_seen >= SQUEEZE_AT) begin
                squeezed   = 1'b1;
                stall_left = 1500;
            end
            if (stall_left > 0) begin
                i_res_stall <= 1'b1;
                stall_left--;
            end else begin
                i_res_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_rx_valid   = 1'b0;
        i_rx_byte    = '0;
        i_res_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_CRC_POLY;
        i_cfg_data   = '0;
        calm         = 1'b0;
        bytes_sent   = 0;
        results_seen = 0;
        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset register values.
        send_frame(RST_SYNC_BYTE, MIN_TOTAL, 1'b0);
        send_frame(RST_ALT_START, 5, 1'b1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(RST_SYNC_BYTE);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(RST_ALT_START);
        send_byte(8'h01);
        send_byte(8'h55);
        send_byte(RST_SYNC_BYTE);
        send_byte(8'd63);
        send_byte(8'h55);
        // The following frame's start byte is read as an oversized length, so the checker resyncs onto it.
        send_byte(RST_SYNC_BYTE);
        send_frame(RST_ALT_START, MIN_TOTAL, 1'b0);

        run_phase(8'h07, 8'h00, 8'hFF, 8'd4, 1'b0, 50);
        run_phase(8'hFF, 8'hFF, 8'h00, 8'd64, 1'b1, 80);
        run_phase(8'h00, 8'hAA, 8'hAA, 8'd3, 1'b0, 25);
        run_phase(RST_CRC_POLY, RST_SYNC_BYTE, RST_ALT_START, 8'hFF, 1'b0, 80);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(4, 64)), 1'b0, 50);

        drain();
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
        end
        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
